[design/mmcs_pkg.sv]
// Package for the min/max contrast stretch block: word types and reset constants.
// Used by min_max_contrast_stretch_top; depends on nothing else.
`timescale 1ns / 1ps

package mmcs_pkg;

  localparam int unsigned PixW = 8;

  localparam logic [PixW-1:0] LowReset  = 8'hFF;
  localparam logic [PixW-1:0] HighReset = 8'h00;

  typedef struct packed {
    logic            func;
    logic [PixW-1:0] pixel;
    logic            last;
  } in_t;

  typedef struct packed {
    logic [PixW-1:0] stretched;
    logic            end_of_frame;
  } out_t;

endpackage

[design/min_max_contrast_stretch_top.sv]
// A measure word is absorbed in its accept cycle and gives no result. An apply word on a
// flat range gives its result in the cycle after acceptance; otherwise the result follows
// the preparation state and the restoring divider, which works out the eight quotient bits,
// one quotient bit per cycle. busy_o is high until the result is shown, so no new word is
// taken while a word is being stretched. Reset sets the minimum to 255, the maximum to 0.
// Depends on mmcs_pkg.
`timescale 1ns / 1ps

module min_max_contrast_stretch_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mmcs_pkg::in_t  in_i,
  output logic           busy_o,
  output logic           valid_o,
  output mmcs_pkg::out_t result_o
);
  import mmcs_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [PixW-1:0] low_q, low_d, high_q, high_d;
  logic [PixW-1:0] diff_q, diff_d;
  logic [PixW-1:0] range_q, range_d;
  logic [PixW-1:0] rem_q, rem_d;
  logic [PixW-1:0] shf_q, shf_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            eof_q, eof_d;
  logic            valid_q, valid_d;
  logic [PixW-1:0] res_q, res_d;

  logic            accept;
  logic            flat;
  logic [PixW-1:0] clamped;
  logic [15:0]     numer;
  logic [PixW:0]   trial;
  logic [PixW:0]   trial_sub;

  assign accept = start_i && (state_q == StIdle);
  assign flat   = (high_q <= low_q);

  always_comb begin
    if (in_i.pixel < low_q) begin
      clamped = low_q;
    end else if (in_i.pixel > high_q) begin
      clamped = high_q;
    end else begin
      clamped = in_i.pixel;
    end
  end

  // Multiplying by 255 is a shift by eight less the value itself.
  assign numer     = {diff_q, 8'h00} - {8'h00, diff_q};
  assign trial     = {rem_q, shf_q[PixW-1]};
  assign trial_sub = trial - {1'b0, range_q};

  always_comb begin
    state_d = state_q;
    low_d   = low_q;
    high_d  = high_q;
    diff_d  = diff_q;
    range_d = range_q;
    rem_d   = rem_q;
    shf_d   = shf_q;
    cnt_d   = cnt_q;
    eof_d   = eof_q;
    valid_d = 1'b0;
    res_d   = res_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (!in_i.func) begin
            if (in_i.pixel < low_q) begin
              low_d = in_i.pixel;
            end
            if (in_i.pixel > high_q) begin
              high_d = in_i.pixel;
            end
          end else begin
            eof_d   = in_i.last;
            diff_d  = clamped - low_q;
            range_d = high_q - low_q;
            if (flat) begin
              valid_d = 1'b1;
              res_d   = in_i.pixel;
            end else begin
              state_d = StPrep;
            end
            if (in_i.last) begin
              low_d  = LowReset;
              high_d = HighReset;
            end
          end
        end
      end
      StPrep: begin
        // The quotient fits in eight bits, so the upper byte is already below the range.
        rem_d   = numer[15:8];
        shf_d   = numer[7:0];
        cnt_d   = 3'd0;
        state_d = StDiv;
      end
      StDiv: begin
        if (!trial_sub[PixW]) begin
          rem_d = trial_sub[PixW-1:0];
          shf_d = {shf_q[PixW-2:0], 1'b1};
        end else begin
          rem_d = trial[PixW-1:0];
          shf_d = {shf_q[PixW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          valid_d = 1'b1;
          res_d   = shf_d;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      low_q   <= LowReset;
      high_q  <= HighReset;
      cnt_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      low_q   <= low_d;
      high_q  <= high_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    range_q <= range_d;
    rem_q   <= rem_d;
    shf_q   <= shf_d;
    eof_q   <= eof_d;
    res_q   <= res_d;
  end

  assign busy_o                = (state_q != StIdle);
  assign valid_o               = valid_q;
  assign result_o.stretched    = res_q;
  assign result_o.end_of_frame = eof_q;

  a_measure_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !in_i.func) |=> !valid_o)
    else $error("A measure word produced a result.");

  a_apply_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && in_i.func) |=> (busy_o || valid_o))
    else $error("An apply word was neither processed nor answered.");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q == 3'd7) |=> (valid_o && !busy_o))
    else $error("The divider finished without giving a result.");

  a_prep_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPrep) |=> (state_q == StDiv && cnt_q == 3'd0 && !valid_o))
    else $error("The divider did not start after preparation.");

endmodule

[bench/tb_min_max_contrast_stretch_top.sv]
// Self-checking bench for min_max_contrast_stretch_top: a directed table, then random frames.
// Each stretched word is checked against a predictor of the block or the table's expected value. Depends on mmcs_pkg.
`timescale 1ns / 1ps

module tb_min_max_contrast_stretch_top;
  import mmcs_pkg::*;

  typedef enum bit {
    Measure = 1'b0,
    Apply   = 1'b1
  } pass_e;

  typedef struct packed {
    pass_e           pass;
    logic [PixW-1:0] pix;
    bit              last;
    bit              typed;
    logic [PixW-1:0] want_pix;
    bit              want_eof;
  } dir_row_t;

  localparam int NumRows    = 22;
  localparam int RandWords  = 1500;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 16;

  localparam dir_row_t DirectedRows [NumRows] = '{
    // Straight after reset the range is empty, so pixels pass through.
    '{Apply,   8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
    '{Apply,   8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
    '{Apply,   8'd170, 1'b1, 1'b1, 8'd170, 1'b1},
    // Full range, with the last mark on a measure word.
    '{Measure, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{Measure, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
    '{Apply,   8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
    '{Apply,   8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
    '{Apply,   8'd128, 1'b0, 1'b1, 8'd128, 1'b0},
    '{Apply,   8'd85,  1'b1, 1'b1, 8'd85,  1'b1},
    // Narrow range, with pixels on both sides of it clamped.
    '{Measure, 8'd200, 1'b0, 1'b0, 8'd0,   1'b0},
    '{Measure, 8'd100, 1'b0, 1'b0, 8'd0,   1'b0},
    '{Measure, 8'd150, 1'b0, 1'b0, 8'd0,   1'b0},
    '{Apply,   8'd50,  1'b0, 1'b1, 8'd0,   1'b0},
    '{Apply,   8'd250, 1'b0, 1'b1, 8'd255, 1'b0},
    '{Apply,   8'd150, 1'b0, 1'b0, 8'd0,   1'b0},
    '{Apply,   8'd101, 1'b1, 1'b0, 8'd0,   1'b0},
    // A flat range passes pixels through without clamping.
    '{Measure, 8'd77,  1'b1, 1'b0, 8'd0,   1'b0},
    '{Apply,   8'd3,   1'b0, 1'b1, 8'd3,   1'b0},
    '{Apply,   8'd200, 1'b1, 1'b1, 8'd200, 1'b1},
    '{Measure, 8'd1,   1'b0, 1'b0, 8'd0,   1'b0},
    '{Measure, 8'd254, 1'b0, 1'b0, 8'd0,   1'b0},
    '{Apply,   8'd127, 1'b1, 1'b0, 8'd0,   1'b0}
  };

  logic clk_i;
  logic rst_ni;
  logic start_i;
  in_t  in_i;
  logic busy_o;
  logic valid_o;
  out_t result_o;

  // Predictor state: the running minimum and maximum of the current frame.
  logic [PixW-1:0] min_seen_q;
  logic [PixW-1:0] max_seen_q;

  out_t stretched_q [$];
  int   err_count;
  int   accepted;
  int   cycle_count;
  int   idle_pct;

  min_max_contrast_stretch_top DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_i     (in_i),
    .busy_o   (busy_o),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (word %0d)", what, got, want, accepted);
    err_count++;
  endtask

  // Updates the frame statistics and tells whether the word gives a result.
  function automatic bit predict_stretch(input in_t w, output out_t r);
    int unsigned p;
    int unsigned span;
    r = '0;
    if (w.func == Measure) begin
      if (w.pixel < min_seen_q) min_seen_q = w.pixel;
      if (w.pixel > max_seen_q) max_seen_q = w.pixel;
      return 1'b0;
    end
    p = w.pixel;
    if (max_seen_q <= min_seen_q) begin
      r.stretched = w.pixel;
    end else begin
      if (p < min_seen_q) p = min_seen_q;
      if (p > max_seen_q) p = max_seen_q;
      span = max_seen_q - min_seen_q;
      r.stretched = PixW'((255 * (p - min_seen_q)) / span);
    end
    r.end_of_frame = w.last;
    if (w.last) begin
      min_seen_q = LowReset;
      max_seen_q = HighReset;
    end
    return 1'b1;
  endfunction

  task automatic send_word(input in_t w, input bit typed, input out_t want);
    out_t predicted;
    bit   gives;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= w;
    do @(posedge clk_i); while (busy_o);
    gives = predict_stretch(w, predicted);
    if (gives) stretched_q.push_back(typed ? want : predicted);
    accepted++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (stretched_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (stretched_q.size() == 0) begin
        report_mismatch("unexpected word", result_o.stretched, -1);
      end else begin
        out_t exp_w;
        exp_w = stretched_q.pop_front();
        if (result_o.stretched !== exp_w.stretched)
          report_mismatch("stretched", result_o.stretched, exp_w.stretched);
        if (result_o.end_of_frame !== exp_w.end_of_frame)
          report_mismatch("end_of_frame", result_o.end_of_frame, exp_w.end_of_frame);
      end
    end
  end

  initial begin
    int   start_count;
    int   kind;
    int   n_meas;
    int   n_apply;
    int   lo_b;
    int   hi_b;
    in_t  w;
    out_t want;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_i        = '0;
    err_count   = 0;
    accepted    = 0;
    idle_pct    = 0;
    min_seen_q  = LowReset;
    max_seen_q  = HighReset;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      w.func               = DirectedRows[i].pass;
      w.pixel              = DirectedRows[i].pix;
      w.last               = DirectedRows[i].last;
      want.stretched       = DirectedRows[i].want_pix;
      want.end_of_frame    = DirectedRows[i].want_eof;
      send_word(w, DirectedRows[i].typed, want);
    end
    // Hold off until the last stretched word is out.
    wait_drained();

    want = '0;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct    = (phase == 0) ? 0 : ((phase == 1) ? 59 : 25);
      start_count = accepted;
      while (accepted - start_count < RandWords / 3) begin
        kind = $urandom_range(9);
        if (kind == 0) begin
          // Noise: any mix of passes and last marks.
          repeat ($urandom_range(6, 1)) begin
            w.func  = 1'($urandom);
            w.pixel = PixW'($urandom);
            w.last  = 1'($urandom);
            send_word(w, 1'b0, want);
          end
        end else begin
          lo_b = $urandom_range(255);
          hi_b = ($urandom_range(7) == 0) ? lo_b : $urandom_range(255, lo_b);
          n_meas  = (kind == 1) ? 0 :
                    (($urandom_range(15) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1));
          n_apply = $urandom_range(8, 1);
          for (int k = 0; k < n_meas; k++) begin
            w.func  = Measure;
            w.pixel = PixW'($urandom_range(hi_b, lo_b));
            w.last  = (k == n_meas - 1) ? 1'($urandom_range(1)) : 1'b0;
            send_word(w, 1'b0, want);
          end
          for (int k = 0; k < n_apply; k++) begin
            w.func  = Apply;
            w.pixel = ($urandom_range(3) == 0) ? PixW'($urandom)
                                               : PixW'($urandom_range(hi_b, lo_b));
            w.last  = (k == n_apply - 1) ? ($urandom_range(9) != 0) : 1'b0;
            send_word(w, 1'b0, want);
          end
        end
      end
      wait_drained();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (stretched_q.size() != 0) report_mismatch("words never seen", 0, stretched_q.size());
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
